// ----- rtl/yaps_pkg.sv -----
package yaps_pkg;

	localparam int PROD_W = 29;
	localparam int SUM_W  = 30;
	localparam int PD_W   = 17;
	localparam int CFG_DW = 15;

	localparam logic [14:0] ABORT_FLOOR = 15'd492;

	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_PHASE = 3'd3;
	localparam logic [2:0] ACT_ESTOP = 3'd4;

	localparam logic [1:0] MODE_STANDBY = 2'd0;
	localparam logic [1:0] MODE_ALIGN   = 2'd1;
	localparam logic [1:0] MODE_PREP    = 2'd2;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FEED   = 2'd1;
	localparam logic [1:0] PH_RETURN = 2'd2;

	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_DAMP_GAIN  = 3'd1;
	localparam logic [2:0] REG_NEGATE     = 3'd2;
	localparam logic [2:0] REG_MIN_RATE   = 3'd3;
	localparam logic [2:0] REG_MAX_RATE   = 3'd4;
	localparam logic [2:0] REG_MAX_STEP   = 3'd5;
	localparam logic [2:0] REG_ALIGN_TOL  = 3'd6;
	localparam logic [2:0] REG_ALIGN_ONLY = 3'd7;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] aim_err;
		logic signed [15:0] gyro_rate;
		logic               gyro_fresh;
		logic               target_locked;
		logic               target_visible;
		logic [1:0]         target_belt;
		logic               lock_granted;
		logic [1:0]         shot_phase;
		logic               estop_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] turn_rate;
		logic               drive_valid;
		logic [1:0]         belt_level;
		logic               tracker_clear;
		logic               mode_changed;
	} out_item_t;

	typedef struct packed {
		logic [11:0] prop_gain;
		logic [11:0] damp_gain;
		logic        negate_command;
		logic [12:0] min_rate;
		logic [14:0] max_rate;
		logic [14:0] max_step;
		logic [12:0] align_tolerance;
		logic        align_only;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic       target_locked;
		logic       target_visible;
		logic [1:0] target_belt;
		logic       lock_granted;
		logic [1:0] shot_phase;
		logic       estop_level;
		logic       in_tol;
		logic       drift;
	} ctl_t;

	typedef struct packed {
		ctl_t                     ctl;
		logic                     gyro_fresh;
		logic signed [PROD_W-1:0] p_term;
		logic signed [PROD_W-1:0] d_term;
	} prod_t;

	typedef struct packed {
		ctl_t                   ctl;
		logic signed [PD_W-1:0] pd_rate;
	} rate_t;

endpackage

// ----- rtl/yaps_front.sv -----
module yaps_front import yaps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     up_valid,
	output logic     up_ready,
	input  in_item_t up_data,
	output logic     dn_valid,
	input  logic     dn_ready,
	output prod_t    dn_data
);

	logic               v_s1;
	in_item_t           item_s1;
	logic signed [12:0] kp_s;
	logic signed [12:0] kd_s;
	logic signed [16:0] err_x;
	logic [16:0]        abs_err;
	logic [14:0]        tol3;
	logic [14:0]        lim;

	assign up_ready = !v_s1 || dn_ready;
	assign dn_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_s1 <= up_data;
		end
	end

	always_comb begin
		kp_s    = {1'b0, cfg.prop_gain};
		kd_s    = {1'b0, cfg.damp_gain};
		err_x   = {item_s1.aim_err[15], item_s1.aim_err};
		abs_err = err_x[16] ? 17'(-err_x) : 17'(err_x);
		tol3    = {2'b0, cfg.align_tolerance} + {1'b0, cfg.align_tolerance, 1'b0};
		lim     = (tol3 < ABORT_FLOOR) ? ABORT_FLOOR : tol3;

		dn_data.p_term             = PROD_W'(kp_s) * PROD_W'(item_s1.aim_err);
		dn_data.d_term             = PROD_W'(kd_s) * PROD_W'(item_s1.gyro_rate);
		dn_data.gyro_fresh         = item_s1.gyro_fresh;
		dn_data.ctl.action         = item_s1.action;
		dn_data.ctl.target_locked  = item_s1.target_locked;
		dn_data.ctl.target_visible = item_s1.target_visible;
		dn_data.ctl.target_belt    = item_s1.target_belt;
		dn_data.ctl.lock_granted   = item_s1.lock_granted;
		dn_data.ctl.shot_phase     = item_s1.shot_phase;
		dn_data.ctl.estop_level    = item_s1.estop_level;
		dn_data.ctl.in_tol         = abs_err < {4'b0, cfg.align_tolerance};
		dn_data.ctl.drift          = abs_err > {2'b0, lim};
	end

endmodule

// ----- rtl/yaps_shape.sv -----
module yaps_shape import yaps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  up_valid,
	output logic  up_ready,
	input  prod_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output rate_t dn_data
);

	logic                    v_s2;
	prod_t                   prod_s2;
	logic signed [SUM_W-1:0] p_x;
	logic signed [SUM_W-1:0] d_x;
	logic signed [SUM_W-1:0] sum_p;
	logic signed [SUM_W-1:0] sum;
	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W-1:0]        mag_r;
	logic [SUM_W-9:0]        mag_q;
	logic [SUM_W-9:0]        lifted;
	logic [14:0]             mag_c;
	logic signed [PD_W-1:0]  mag_s;

	assign up_ready = !v_s2 || dn_ready;
	assign dn_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (up_ready) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			prod_s2 <= up_data;
		end
	end

	// sum, round half away from zero, then floor and ceiling on magnitude
	always_comb begin
		p_x    = {prod_s2.p_term[PROD_W-1], prod_s2.p_term};
		d_x    = {prod_s2.d_term[PROD_W-1], prod_s2.d_term};
		sum_p  = cfg.negate_command ? -p_x : p_x;
		sum    = prod_s2.gyro_fresh ? (sum_p - d_x) : sum_p;
		neg    = sum[SUM_W-1];
		mag    = neg ? SUM_W'(-sum) : SUM_W'(sum);
		mag_r  = mag + SUM_W'(128);
		mag_q  = mag_r[SUM_W-1:8];
		lifted = (mag_q < {9'b0, cfg.min_rate}) ? {9'b0, cfg.min_rate} : mag_q;
		mag_c  = (lifted > {7'b0, cfg.max_rate}) ? cfg.max_rate : lifted[14:0];
		mag_s  = {2'b0, mag_c};

		dn_data.ctl     = prod_s2.ctl;
		dn_data.pd_rate = neg ? -mag_s : mag_s;
	end

endmodule

// ----- rtl/yaps_mode_ctl.sv -----
module yaps_mode_ctl import yaps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      up_valid,
	output logic      up_ready,
	input  rate_t     up_data,
	output logic      dn_valid,
	input  logic      dn_ready,
	output out_item_t dn_data
);

	logic               v_s3;
	rate_t              rate_s3;
	logic               res_valid_q;
	out_item_t          res_q;
	logic [1:0]         mode_q;
	logic signed [15:0] last_rate_q;
	logic [1:0]         prev_phase_q;
	logic               estop_q;
	logic               load;
	logic               fire;

	logic [1:0]         mode_n;
	logic signed [15:0] last_n;
	logic               estop_n;
	logic signed [15:0] rate_n;
	logic [1:0]         belt_n;
	logic               drive_n;
	logic               clear_n;
	logic [1:0]         belt_sel;
	logic signed [17:0] last_x;
	logic signed [17:0] hi;
	logic signed [17:0] lo;
	logic signed [17:0] r_x;
	logic signed [17:0] slewed;
	ctl_t               c;

	assign up_ready = !v_s3 || !res_valid_q || dn_ready;
	assign load     = up_valid && up_ready;
	assign fire     = v_s3 && (!res_valid_q || dn_ready);
	assign dn_valid = res_valid_q;
	assign dn_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (up_ready) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rate_s3 <= up_data;
		end
	end

	// slew limit against the last command
	always_comb begin
		last_x = {{2{last_rate_q[15]}}, last_rate_q};
		hi     = last_x + {3'b0, cfg.max_step};
		lo     = last_x - {3'b0, cfg.max_step};
		r_x    = {rate_s3.pd_rate[PD_W-1], rate_s3.pd_rate};
		if (r_x > hi) begin
			slewed = hi;
		end else if (r_x < lo) begin
			slewed = lo;
		end else begin
			slewed = r_x;
		end
	end

	always_comb begin
		c        = rate_s3.ctl;
		mode_n   = mode_q;
		last_n   = last_rate_q;
		estop_n  = estop_q;
		rate_n   = '0;
		belt_n   = '0;
		drive_n  = 1'b0;
		clear_n  = 1'b0;
		belt_sel = cfg.align_only ? 2'd0 : c.target_belt;
		unique case (c.action)
			ACT_TICK: begin
				if (!estop_q) begin
					if (mode_q == MODE_STANDBY) begin
						last_n = '0;
					end else if (mode_q == MODE_ALIGN) begin
						if (!c.target_locked) begin
							mode_n = MODE_STANDBY;
						end else if (c.target_visible && c.in_tol) begin
							last_n = '0;
							mode_n = MODE_PREP;
							belt_n = belt_sel;
						end else begin
							rate_n = slewed[15:0];
							last_n = slewed[15:0];
						end
					end else if (mode_q == MODE_PREP) begin
						last_n = '0;
						belt_n = belt_sel;
						if (c.drift) begin
							mode_n = MODE_ALIGN;
						end
					end
				end
				drive_n = (mode_n != MODE_STANDBY);
			end
			ACT_START: begin
				if (mode_q == MODE_STANDBY && c.lock_granted) begin
					mode_n = MODE_ALIGN;
				end
			end
			ACT_STOP: begin
				if (mode_q != MODE_STANDBY) begin
					mode_n  = MODE_STANDBY;
					clear_n = 1'b1;
				end
			end
			ACT_PHASE: begin
				if ((mode_q == MODE_ALIGN || mode_q == MODE_PREP) &&
				    ((c.shot_phase == PH_RETURN && prev_phase_q == PH_FEED) ||
				     (c.shot_phase == PH_IDLE && prev_phase_q == PH_RETURN))) begin
					mode_n  = MODE_STANDBY;
					clear_n = 1'b1;
				end
			end
			ACT_ESTOP: begin
				estop_n = c.estop_level;
				if (c.estop_level) begin
					mode_n = MODE_STANDBY;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			mode_q       <= MODE_STANDBY;
			last_rate_q  <= '0;
			prev_phase_q <= PH_IDLE;
			estop_q      <= 1'b0;
		end else begin
			if (fire) begin
				res_valid_q <= 1'b1;
				mode_q      <= mode_n;
				last_rate_q <= last_n;
				estop_q     <= estop_n;
				if (c.action == ACT_PHASE) begin
					prev_phase_q <= c.shot_phase;
				end
			end else if (dn_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.mode          <= mode_n;
			res_q.turn_rate     <= rate_n;
			res_q.drive_valid   <= drive_n;
			res_q.belt_level    <= belt_n;
			res_q.tracker_clear <= clear_n;
			res_q.mode_changed  <= (mode_n != mode_q);
		end
	end

endmodule

// ----- rtl/yaw_aim_pd_slew_controller_unit.sv -----
// Yaw aiming controller: standby, aligning and preparing modes with a PD turn
// rate that is floored, clamped and slew limited on ticks while aligning. One
// item is taken per clock while res_ready is high and yields exactly one
// result; the item passes through the input register, gain multiplies, rate
// shaping, then mode and slew update into the result register. The mode,
// last command, shot phase and emergency stop state change only in the last
// stage, so items may follow each other in consecutive cycles. Registers are
// written through cfg_wen/cfg_idx/cfg_wdata and should change only while no
// item is in flight.
module yaw_aim_pd_slew_controller_unit import yaps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  in_item_t          item,
	output logic              res_valid,
	input  logic              res_ready,
	output out_item_t         res,
	input  logic              cfg_wen,
	input  logic [2:0]        cfg_idx,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  prod_valid;
	logic  prod_ready;
	prod_t prod;
	logic  rate_valid;
	logic  rate_ready;
	rate_t rate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= 12'd282;
			cfg_q.damp_gain       <= 12'd90;
			cfg_q.negate_command  <= 1'b1;
			cfg_q.min_rate        <= 13'd123;
			cfg_q.max_rate        <= 15'd2048;
			cfg_q.max_step        <= 15'd246;
			cfg_q.align_tolerance <= 13'd66;
			cfg_q.align_only      <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:  cfg_q.prop_gain       <= cfg_wdata[11:0];
				REG_DAMP_GAIN:  cfg_q.damp_gain       <= cfg_wdata[11:0];
				REG_NEGATE:     cfg_q.negate_command  <= cfg_wdata[0];
				REG_MIN_RATE:   cfg_q.min_rate        <= cfg_wdata[12:0];
				REG_MAX_RATE:   cfg_q.max_rate        <= cfg_wdata[14:0];
				REG_MAX_STEP:   cfg_q.max_step        <= cfg_wdata[14:0];
				REG_ALIGN_TOL:  cfg_q.align_tolerance <= cfg_wdata[12:0];
				REG_ALIGN_ONLY: cfg_q.align_only      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	yaps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.up_data  (item),
		.dn_valid (prod_valid),
		.dn_ready (prod_ready),
		.dn_data  (prod)
	);

	yaps_shape u_shape (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (prod_valid),
		.up_ready (prod_ready),
		.up_data  (prod),
		.dn_valid (rate_valid),
		.dn_ready (rate_ready),
		.dn_data  (rate)
	);

	yaps_mode_ctl u_mode_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (rate_valid),
		.up_ready (rate_ready),
		.up_data  (rate),
		.dn_valid (res_valid),
		.dn_ready (res_ready),
		.dn_data  (res)
	);

endmodule
